>>> rtl/qab_pkg.sv
package qab_pkg;

  localparam int CoordW      = 16;
  localparam int FracBitsDef = 4;
  localparam int RootBits    = 18;
  localparam int QueueDepth  = 2;
  localparam int SumW        = CoordW + 2;
  localparam int DiffW       = CoordW + 1;
  localparam int SizeW       = RootBits + 1;

  // one input word: four corners
  typedef struct packed {
    logic signed [CoordW-1:0] corner0_x;
    logic signed [CoordW-1:0] corner0_y;
    logic signed [CoordW-1:0] corner1_x;
    logic signed [CoordW-1:0] corner1_y;
    logic signed [CoordW-1:0] corner2_x;
    logic signed [CoordW-1:0] corner2_y;
    logic signed [CoordW-1:0] corner3_x;
    logic signed [CoordW-1:0] corner3_y;
  } in_item_t;

  // one result word
  typedef struct packed {
    logic signed [CoordW-1:0] box_left;
    logic signed [CoordW-1:0] box_top;
    logic        [CoordW-1:0] box_width;
    logic        [CoordW-1:0] box_height;
    logic                     degenerate;
  } out_item_t;

  // values carried alongside the root pipelines
  typedef struct packed {
    logic        [CoordW-1:0] w;
    logic        [CoordW-1:0] h;
    logic signed [SumW-1:0]   sx;
    logic signed [SumW-1:0]   sy;
    logic                     degen;
  } side_t;

  // classified word handed from front to back
  typedef struct packed {
    logic signed [DiffW-1:0] d01x;
    logic signed [DiffW-1:0] d01y;
    logic signed [DiffW-1:0] d12x;
    logic signed [DiffW-1:0] d12y;
    side_t                   side;
  } front_t;

endpackage

>>> rtl/qab_if.sv
interface qab_in_if;
  import qab_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qab_out_if;
  import qab_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/qab_front.sv
module qab_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  qab_in_if.sink          in_i,
  output logic            valid_o,
  output qab_pkg::front_t item_o,
  input  logic            ready_i
);
  import qab_pkg::*;

  logic signed [CoordW-1:0] xs [4];
  logic signed [CoordW-1:0] ys [4];
  logic signed [CoordW-1:0] xmin, xmax, ymin, ymax;
  logic signed [DiffW-1:0]  wd, hd;
  logic signed [SumW-1:0]   sx, sy;
  logic                     vld_q;
  front_t                   item_q, item_d;

  // corner unpacking
  always_comb begin
    xs[0] = in_i.data.corner0_x;
    xs[1] = in_i.data.corner1_x;
    xs[2] = in_i.data.corner2_x;
    xs[3] = in_i.data.corner3_x;
    ys[0] = in_i.data.corner0_y;
    ys[1] = in_i.data.corner1_y;
    ys[2] = in_i.data.corner2_y;
    ys[3] = in_i.data.corner3_y;
  end

  // bounding box and corner sums
  always_comb begin
    xmin = xs[0];
    xmax = xs[0];
    ymin = ys[0];
    ymax = ys[0];
    sx   = SumW'(xs[0]);
    sy   = SumW'(ys[0]);
    for (int i = 1; i < 4; i++) begin
      if (xs[i] < xmin) xmin = xs[i];
      if (xs[i] > xmax) xmax = xs[i];
      if (ys[i] < ymin) ymin = ys[i];
      if (ys[i] > ymax) ymax = ys[i];
      sx = sx + SumW'(xs[i]);
      sy = sy + SumW'(ys[i]);
    end
  end

  assign wd = DiffW'(xmax) - DiffW'(xmin);
  assign hd = DiffW'(ymax) - DiffW'(ymin);

  // edge differences and sideband
  always_comb begin
    item_d.d01x       = DiffW'(xs[0]) - DiffW'(xs[1]);
    item_d.d01y       = DiffW'(ys[0]) - DiffW'(ys[1]);
    item_d.d12x       = DiffW'(xs[1]) - DiffW'(xs[2]);
    item_d.d12y       = DiffW'(ys[1]) - DiffW'(ys[2]);
    item_d.side.w     = wd[CoordW-1:0];
    item_d.side.h     = hd[CoordW-1:0];
    item_d.side.sx    = sx;
    item_d.side.sy    = sy;
    item_d.side.degen = (wd == '0) || (hd == '0);
  end

  assign in_i.ready = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= item_d;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

>>> rtl/qab_fifo.sv
module qab_fifo #(
  parameter int Depth = qab_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  qab_pkg::front_t item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output qab_pkg::front_t item_o
);
  import qab_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  front_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign ready_o = cnt_q != CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end

endmodule

>>> rtl/qab_isqrt.sv
module qab_isqrt #(
  parameter int Width = 68,
  parameter int SideW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [Width-1:0]   rad_i,
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output logic [Width/2-1:0] root_o,
  output logic [SideW-1:0]   side_o
);

  localparam int Steps = Width / 2;
  localparam int RemW  = Steps + 1;
  localparam int CurW  = RemW + 2;

  logic [Width-1:0] rad_q  [Steps];
  logic [RemW-1:0]  rem_q  [Steps];
  logic [Steps-1:0] root_q [Steps];
  logic [SideW-1:0] side_q [Steps];
  logic             vld_q  [Steps];

  // one result bit per stage, restoring form
  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [Width-1:0] rad_in;
    logic [RemW-1:0]  rem_in;
    logic [Steps-1:0] root_in;
    logic [SideW-1:0] side_in;
    logic             vld_in;
    logic [CurW-1:0]  cur, trial, diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign cur   = {rem_in, rad_in[Width-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= rad_in << 2;
        rem_q[i]  <= ge ? diff[RemW-1:0] : cur[RemW-1:0];
        root_q[i] <= {root_in[Steps-2:0], ge};
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

>>> rtl/qab_back.sv
module qab_back #(
  parameter int FRAC_BITS = qab_pkg::FracBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  qab_pkg::front_t item_i,
  qab_out_if.source       out_o
);
  import qab_pkg::*;

  localparam int SideBits = $bits(side_t);
  localparam int RadW     = 134;
  localparam int G1W      = RadW / 2;
  localparam int G2W      = (G1W + 1) / 2;

  logic adv;

  // whole back end moves when the output register can take a word
  assign adv     = !out_o.valid || out_o.ready;
  assign ready_o = adv;

  // stage 1: squares of the edge differences, box product
  logic signed [2*DiffW-1:0] p0, p1, p2, p3;
  logic        [31:0]        sq0_q, sq1_q, sq2_q, sq3_q, u1_q;
  logic                      v1_q;
  side_t                     sd1_q;

  assign p0 = item_i.d01x * item_i.d01x;
  assign p1 = item_i.d01y * item_i.d01y;
  assign p2 = item_i.d12x * item_i.d12x;
  assign p3 = item_i.d12y * item_i.d12y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq0_q <= p0[31:0];
      sq1_q <= p1[31:0];
      sq2_q <= p2[31:0];
      sq3_q <= p3[31:0];
      u1_q  <= item_i.side.w * item_i.side.h;
      sd1_q <= item_i.side;
    end
  end

  // stage 2: edge lengths squared, box product squared
  logic [32:0] s1_q, s2_q;
  logic [63:0] v2_q;
  logic        v2v_q;
  side_t       sd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2v_q <= 1'b0;
    end else if (adv) begin
      v2v_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= {1'b0, sq0_q} + {1'b0, sq1_q};
      s2_q  <= {1'b0, sq2_q} + {1'b0, sq3_q};
      v2_q  <= u1_q * u1_q;
      sd2_q <= sd1_q;
    end
  end

  // stage 3: product of the edge lengths squared, S1 * S2
  logic [65:0] k3_q;
  logic [63:0] v3_q;
  logic        v3v_q;
  side_t       sd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3v_q <= 1'b0;
    end else if (adv) begin
      v3v_q <= v2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k3_q  <= s1_q * s2_q;
      v3_q  <= v2_q;
      sd3_q <= sd2_q;
    end
  end

  // stage 4: partial products of the wide radicand
  logic [63:0] pp_ll_q, pp_lh_q;
  logic [65:0] pp_hl_q, pp_hh_q;
  logic        v4v_q;
  side_t       sd4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4v_q <= 1'b0;
    end else if (adv) begin
      v4v_q <= v3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_ll_q <= k3_q[31:0] * v3_q[31:0];
      pp_lh_q <= k3_q[31:0] * v3_q[63:32];
      pp_hl_q <= k3_q[65:32] * v3_q[31:0];
      pp_hh_q <= k3_q[65:32] * v3_q[63:32];
      sd4_q   <= sd3_q;
    end
  end

  // stage 5: radicand 16 * S1 * S2 * (W*H)^2
  logic [RadW-5:0] n5;
  logic [RadW-1:0] rad5_q;
  logic            v5v_q;
  side_t           sd5_q;

  assign n5 = (RadW-4)'(pp_ll_q) + ((RadW-4)'(pp_lh_q) << 32)
            + ((RadW-4)'(pp_hl_q) << 32) + ((RadW-4)'(pp_hh_q) << 64);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5v_q <= 1'b0;
    end else if (adv) begin
      v5v_q <= v4v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad5_q <= {n5, 4'b0000};
      sd5_q  <= sd4_q;
    end
  end

  // fourth root as two chained square roots
  logic                vg1, vg2;
  logic [G1W-1:0]      g1;
  logic [G2W-1:0]      g2;
  logic [SideBits-1:0] sdg1, sdg2;

  qab_isqrt #(.Width(RadW), .SideW(SideBits)) u_sqrt_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5v_q),
    .rad_i   (rad5_q),
    .side_i  (sd5_q),
    .valid_o (vg1),
    .root_o  (g1),
    .side_o  (sdg1)
  );

  qab_isqrt #(.Width(2 * G2W), .SideW(SideBits)) u_sqrt_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vg1),
    .rad_i   ((2 * G2W)'(g1)),
    .side_i  (sdg1),
    .valid_o (vg2),
    .root_o  (g2),
    .side_o  (sdg2)
  );

  // divide set-up: overflow means the quotient does not fit and saturates
  side_t                sdg2_s;
  logic                 d0v_q, ovw0_q, ovh0_q;
  logic [RootBits-1:0]  lo0_q;
  logic [CoordW-1:0]    rw0_q, rh0_q;
  side_t                sd0_q;

  assign sdg2_s = side_t'(sdg2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0v_q <= 1'b0;
    end else if (adv) begin
      d0v_q <= vg2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ovw0_q <= CoordW'(g2[G2W-1:RootBits]) >= sdg2_s.h;
      ovh0_q <= CoordW'(g2[G2W-1:RootBits]) >= sdg2_s.w;
      rw0_q  <= CoordW'(g2[G2W-1:RootBits]);
      rh0_q  <= CoordW'(g2[G2W-1:RootBits]);
      lo0_q  <= g2[RootBits-1:0];
      sd0_q  <= sdg2_s;
    end
  end

  // long division of the root by H (width) and by W (height)
  logic                dv_q  [RootBits];
  logic                ovw_q [RootBits];
  logic                ovh_q [RootBits];
  logic [CoordW-1:0]   rmw_q [RootBits];
  logic [CoordW-1:0]   rmh_q [RootBits];
  logic [RootBits-1:0] qw_q  [RootBits];
  logic [RootBits-1:0] qh_q  [RootBits];
  logic [RootBits-1:0] lo_q  [RootBits];
  side_t               sdd_q [RootBits];

  for (genvar i = 0; i < RootBits; i++) begin : g_div
    logic                vin, ovw_in, ovh_in;
    logic [CoordW-1:0]   rmw_in, rmh_in;
    logic [RootBits-1:0] qw_in, qh_in, lo_in;
    side_t               sd_in;
    logic [CoordW:0]     curw, curh, difw, difh;
    logic                gew, geh;

    if (i == 0) begin : g_first
      assign vin    = d0v_q;
      assign ovw_in = ovw0_q;
      assign ovh_in = ovh0_q;
      assign rmw_in = rw0_q;
      assign rmh_in = rh0_q;
      assign qw_in  = '0;
      assign qh_in  = '0;
      assign lo_in  = lo0_q;
      assign sd_in  = sd0_q;
    end else begin : g_next
      assign vin    = dv_q[i-1];
      assign ovw_in = ovw_q[i-1];
      assign ovh_in = ovh_q[i-1];
      assign rmw_in = rmw_q[i-1];
      assign rmh_in = rmh_q[i-1];
      assign qw_in  = qw_q[i-1];
      assign qh_in  = qh_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign sd_in  = sdd_q[i-1];
    end

    assign curw = {rmw_in, lo_in[RootBits-1]};
    assign curh = {rmh_in, lo_in[RootBits-1]};
    assign gew  = curw >= {1'b0, sd_in.h};
    assign geh  = curh >= {1'b0, sd_in.w};
    assign difw = curw - {1'b0, sd_in.h};
    assign difh = curh - {1'b0, sd_in.w};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i] <= 1'b0;
      end else if (adv) begin
        dv_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ovw_q[i] <= ovw_in;
        ovh_q[i] <= ovh_in;
        rmw_q[i] <= gew ? difw[CoordW-1:0] : curw[CoordW-1:0];
        rmh_q[i] <= geh ? difh[CoordW-1:0] : curh[CoordW-1:0];
        qw_q[i]  <= {qw_in[RootBits-2:0], gew};
        qh_q[i]  <= {qh_in[RootBits-2:0], geh};
        lo_q[i]  <= lo_in << 1;
        sdd_q[i] <= sd_in;
      end
    end
  end

  // rounding, one pixel margin, centring and saturation
  side_t                 sdf;
  logic [RootBits-1:0]   rw, rh;
  logic [RootBits:0]     hw, hh;
  logic [SizeW-1:0]      one, wid, hei;
  logic signed [SumW+3:0] tl, tt, el, et;
  out_item_t             res_d, res_q;
  logic                  out_v_q;

  assign sdf = sdd_q[RootBits-1];
  assign one = SizeW'(1) << FRAC_BITS;
  assign rw  = ovw_q[RootBits-1] ? '1 : qw_q[RootBits-1];
  assign rh  = ovh_q[RootBits-1] ? '1 : qh_q[RootBits-1];
  assign hw  = ({1'b0, rw} + 1'b1) >> 1;
  assign hh  = ({1'b0, rh} + 1'b1) >> 1;
  assign wid = sdf.degen ? SizeW'(sdf.w) + one : SizeW'(hw) + one;
  assign hei = sdf.degen ? SizeW'(sdf.h) + one : SizeW'(hh) + one;
  assign tl  = (SumW+4)'(sdf.sx) - $signed({2'b00, wid, 1'b0}) + 2;
  assign tt  = (SumW+4)'(sdf.sy) - $signed({2'b00, hei, 1'b0}) + 2;
  assign el  = tl >>> 2;
  assign et  = tt >>> 2;

  always_comb begin
    res_d.degenerate = sdf.degen;
    res_d.box_width  = (wid > SizeW'(16'hFFFF)) ? 16'hFFFF : wid[CoordW-1:0];
    res_d.box_height = (hei > SizeW'(16'hFFFF)) ? 16'hFFFF : hei[CoordW-1:0];
    if (el > (SumW+4)'(32767)) res_d.box_left = 16'sh7FFF;
    else if (el < -(SumW+4)'(32768)) res_d.box_left = -16'sh8000;
    else res_d.box_left = el[CoordW-1:0];
    if (et > (SumW+4)'(32767)) res_d.box_top = 16'sh7FFF;
    else if (et < -(SumW+4)'(32768)) res_d.box_top = -16'sh8000;
    else res_d.box_top = et[CoordW-1:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_q[RootBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = res_q;

endmodule

>>> rtl/quad_to_area_preserving_box.sv
// an accepted word passes the front register, the queue and the back end in that order
// throughput: one word per cycle; the back end is fully pipelined, and its depth is set
//   by the two chained square-root pipelines (67 and 34 steps) and the 18-step divide
// the whole back end holds while the output register is full and not taken
// reset: clears valid bits, queue pointers and fill count only; no clearing pass
module quad_to_area_preserving_box #(
  parameter int FRAC_BITS = qab_pkg::FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qab_in_if.sink    in_i,
  qab_out_if.source out_o
);
  import qab_pkg::*;

  logic   fr_valid, fr_ready, q_valid, bk_ready;
  front_t fr_item, q_item;

  // accept and classify
  qab_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (fr_valid),
    .item_o  (fr_item),
    .ready_i (fr_ready)
  );

  // short queue between front and back
  qab_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .item_i  (fr_item),
    .valid_o (q_valid),
    .ready_i (bk_ready),
    .item_o  (q_item)
  );

  // root search, divide and output
  qab_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ready_o (bk_ready),
    .item_i  (q_item),
    .out_o   (out_o)
  );

  // every result carries at least the one pixel margin
  a_min_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.box_width >= (16'(1) << FRAC_BITS))
                 && (out_o.data.box_height >= (16'(1) << FRAC_BITS)))
    else $error("result smaller than margin");

  // a full queue is never empty
  a_queue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fr_ready |-> q_valid)
    else $error("queue full and empty");

  // back end only holds behind a waiting result
  a_back_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bk_ready |-> out_o.valid)
    else $error("back end stalled without a result");

endmodule

>>> test/tb.sv
module tb;
  import qab_pkg::*;

  localparam int HoldLimit = 4000;
  localparam int NumRandom = 1300;
  localparam int DrainWait = 200;

  logic clk;
  logic rst_n;

  qab_in_if  in_if ();
  qab_out_if out_if ();

  quad_to_area_preserving_box u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // expected boxes, one per accepted quad word
  class box_scoreboard;
    out_item_t pending_boxes[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function void report(string what, longint got, longint want);
      errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endfunction

    // fourth root of 16*s1*s2*num^2/den^2, bit by bit, then round half up
    function automatic longint scaled_side(longint unsigned s1, longint unsigned s2,
                                           longint unsigned num, longint unsigned den);
      logic [127:0]    rhs;
      logic [127:0]    lhs;
      longint unsigned x;
      longint unsigned r;
      longint unsigned c;
      rhs = 128'(s1 * 4 * num) * 128'(s2 * 4 * num);
      r = 0;
      for (int b = RootBits - 1; b >= 0; b--) begin
        c = r | (longint'(1) << b);
        x = c * c * den;
        lhs = 128'(x) * 128'(x);
        if (lhs <= rhs) r = c;
      end
      return longint'((r + 1) >> 1);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // floor((sum - 2*size + 2) / 4)
    function automatic longint edge_at(longint sum, longint size);
      return (sum - 2 * size + 2) >>> 2;
    endfunction

    function void note_quad(in_item_t q);
      longint    xs[4];
      longint    ys[4];
      longint    xmin, xmax, ymin, ymax, sx, sy, w, h, wid, hei, d1, d2, d3, d4;
      longint    unit;
      longint unsigned s1, s2;
      out_item_t e;
      xs[0] = q.corner0_x; ys[0] = q.corner0_y;
      xs[1] = q.corner1_x; ys[1] = q.corner1_y;
      xs[2] = q.corner2_x; ys[2] = q.corner2_y;
      xs[3] = q.corner3_x; ys[3] = q.corner3_y;
      xmin = xs[0]; xmax = xs[0]; ymin = ys[0]; ymax = ys[0];
      sx = 0; sy = 0;
      for (int i = 0; i < 4; i++) begin
        if (xs[i] < xmin) xmin = xs[i];
        if (xs[i] > xmax) xmax = xs[i];
        if (ys[i] < ymin) ymin = ys[i];
        if (ys[i] > ymax) ymax = ys[i];
        sx += xs[i];
        sy += ys[i];
      end
      w = xmax - xmin;
      h = ymax - ymin;
      unit = longint'(1) << FracBitsDef;
      d1 = xs[0] - xs[1]; d2 = ys[0] - ys[1];
      d3 = xs[1] - xs[2]; d4 = ys[1] - ys[2];
      s1 = d1 * d1 + d2 * d2;
      s2 = d3 * d3 + d4 * d4;
      e.degenerate = (w == 0 || h == 0);
      if (e.degenerate) begin
        wid = w + unit;
        hei = h + unit;
      end else begin
        wid = scaled_side(s1, s2, w, h) + unit;
        hei = scaled_side(s1, s2, h, w) + unit;
      end
      e.box_left   = 16'(clamp(edge_at(sx, wid), -32768, 32767));
      e.box_top    = 16'(clamp(edge_at(sy, hei), -32768, 32767));
      e.box_width  = 16'(clamp(wid, 0, 65535));
      e.box_height = 16'(clamp(hei, 0, 65535));
      pending_boxes = {pending_boxes, e};
    endfunction

    function void check_box(out_item_t got);
      out_item_t e;
      if (pending_boxes.size() == 0) begin
        errors++;
        $display("unexpected box word at %0t", $realtime);
        return;
      end
      e = pending_boxes.pop_front();
      if (got.box_left !== e.box_left) report("box_left", got.box_left, e.box_left);
      if (got.box_top !== e.box_top) report("box_top", got.box_top, e.box_top);
      if (got.box_width !== e.box_width) report("box_width", got.box_width, e.box_width);
      if (got.box_height !== e.box_height)
        report("box_height", got.box_height, e.box_height);
      if (got.degenerate !== e.degenerate)
        report("degenerate", got.degenerate, e.degenerate);
    endfunction
  endclass

  box_scoreboard sb;
  int            idle_cycles;
  bit            busy_phase;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // gap lengths: mostly none or short, a few long
  function automatic int pick_gap();
    int k;
    if (busy_phase) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_quad(int kind);
    in_item_t q;
    logic signed [15:0] cx, cy;
    int span;
    q = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    case (kind)
      // a region with random extent around a random centre
      3, 4, 5, 6: begin
        span = 1 << $urandom_range(1, 12);
        cx = 16'($urandom_range(0, 40000) - 20000);
        cy = 16'($urandom_range(0, 40000) - 20000);
        q.corner0_x = cx + 16'($urandom_range(0, 2 * span) - span);
        q.corner0_y = cy + 16'($urandom_range(0, 2 * span) - span);
        q.corner1_x = cx + 16'($urandom_range(0, 2 * span) - span);
        q.corner1_y = cy + 16'($urandom_range(0, 2 * span) - span);
        q.corner2_x = cx + 16'($urandom_range(0, 2 * span) - span);
        q.corner2_y = cy + 16'($urandom_range(0, 2 * span) - span);
        q.corner3_x = cx + 16'($urandom_range(0, 2 * span) - span);
        q.corner3_y = cy + 16'($urandom_range(0, 2 * span) - span);
      end
      // flat bounding box in x or y
      7: begin
        if ($urandom_range(0, 1)) begin
          q.corner1_x = q.corner0_x; q.corner2_x = q.corner0_x; q.corner3_x = q.corner0_x;
        end else begin
          q.corner1_y = q.corner0_y; q.corner2_y = q.corner0_y; q.corner3_y = q.corner0_y;
        end
      end
      // a zero-length edge
      8: begin
        if ($urandom_range(0, 1)) begin
          q.corner1_x = q.corner0_x; q.corner1_y = q.corner0_y;
        end else begin
          q.corner2_x = q.corner1_x; q.corner2_y = q.corner1_y;
        end
      end
      9: begin
        q.corner0_x = pick_extreme(); q.corner0_y = pick_extreme();
        q.corner1_x = pick_extreme(); q.corner1_y = pick_extreme();
        q.corner2_x = pick_extreme(); q.corner2_y = pick_extreme();
        q.corner3_x = pick_extreme(); q.corner3_y = pick_extreme();
      end
      default: ;
    endcase
    return q;
  endfunction

  // present one word and hold it until taken
  task automatic send_quad(in_item_t q);
    int gap;
    in_if.data  <= q;
    in_if.valid <= 1'b1;
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_corners(int x0, int y0, int x1, int y1, int x2, int y2,
                              int x3, int y3);
    in_item_t q;
    q.corner0_x = 16'(x0); q.corner0_y = 16'(y0);
    q.corner1_x = 16'(x1); q.corner1_y = 16'(y1);
    q.corner2_x = 16'(x2); q.corner2_y = 16'(y2);
    q.corner3_x = 16'(x3); q.corner3_y = 16'(y3);
    send_quad(q);
  endtask

  // sink side: random back-pressure with occasional long stalls
  int stall_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (busy_phase) begin
      out_if.ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:64]:  out_if.ready <= 1'b1;
        [65:95]: out_if.ready <= 1'b0;
        default: begin
          out_if.ready <= 1'b0;
          stall_left   <= $urandom_range(10, 40);
        end
      endcase
    end
  end

  // handshakes are stable at the falling edge and complete at the next rising one
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_quad(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_box(out_if.data);
    end
  end

  // watchdog on cycles with no word moving
  always @(negedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HoldLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb          = new();
    busy_phase  = 1'b0;
    rst_n       = 1'b0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_corners(0, 0, 0, 0, 0, 0, 0, 0);
    send_corners(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_corners(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_corners(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767);
    send_corners(0, 0, 16, 0, 16, 16, 0, 16);
    send_corners(100, 200, 740, 200, 740, 520, 100, 520);
    send_corners(160, 0, 320, 160, 160, 320, 0, 160);
    send_corners(-50, 30, 400, 30, -7, 30, 90, 30);
    send_corners(-50, 30, -50, 900, -50, -300, -50, 5);
    send_corners(55, 55, 55, 55, 100, 300, 20, 10);
    send_corners(55, 55, 300, 90, 300, 90, 20, 10);
    send_corners(-32768, 0, 32767, 1, -32768, 0, 32767, 1);
    send_corners(0, -32768, 1, 32767, 0, -32768, 1, 32767);
    send_corners(-32768, -32768, 32767, 32767, -32768, -32768, 0, 0);
    send_corners(0, 0, 32767, 32767, 0, 32767, 32767, 0);
    send_corners(-1, -1, 1, 1, -1, 1, 1, -1);
    send_corners(10, 10, 40, 20, 15, 35, -20, 50);
    send_corners(20000, -20000, 32767, -32768, -32768, 32767, 1, -1);

    // random quads, with stretches at full rate
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 200 == 0) busy_phase = ($urandom_range(0, 2) == 0);
      send_quad(make_quad($urandom_range(0, 9)));
    end
    in_if.valid <= 1'b0;
    busy_phase = 1'b0;

    // drain
    while (sb.pending_boxes.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
